@@ design/dmx_pkg.sv @@
// Shared types and constants for the dynamic-exclusion direct-mapped cache.
package dmx_pkg;

	localparam int ADDR_BITS      = 30;
	localparam int THR_BITS       = 16;
	localparam int TOTAL_BITS     = 32;
	localparam int INDEX_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF = 16;

	// APB register map: one 32-bit register every 4 bytes
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

	localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_WARMUP    = 1'd1;

	typedef struct packed {
		logic                 data_fetch;
		logic [ADDR_BITS-1:0] fetch_address;
	} fetch_t;

	typedef struct packed {
		logic                  counted;
		logic                  hit;
		logic                  replaced;
		logic                  in_warmup;
		logic [TOTAL_BITS-1:0] access_total;
		logic [TOTAL_BITS-1:0] miss_total;
	} result_t;

endpackage

@@ design/dm_cache_dynamic_exclusion_core.sv @@
// Top level: direct-mapped instruction cache with dynamic exclusion and APB registers.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+--------------------------
//  fetch    | fetch_valid / fetch_ready      | fetch  (dmx_pkg::fetch_t)
//  result   | result_valid / result_ready    | result (dmx_pkg::result_t)
//  config   | psel penable pwrite / pready=1 | paddr, pwdata, prdata
//
// Each beat passes through the line RAM read, then the update of the line and the
// load of the result register. A result waiting in its output register
// holds the update cycle, so a stalled result stalls the fetch side.
// After reset the line RAM is swept once over every line before the
// first fetch beat is taken; register writes are taken during the sweep.
module dm_cache_dynamic_exclusion_core #(
	parameter int INDEX_BITS = dmx_pkg::INDEX_BITS_DEF,
	parameter int COUNT_BITS = dmx_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fetch_valid,
	output logic                              fetch_ready,
	input  dmx_pkg::fetch_t                   fetch,
	output logic                              result_valid,
	input  logic                              result_ready,
	output dmx_pkg::result_t                  result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dmx_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [dmx_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [dmx_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready
);

	import dmx_pkg::*;

	localparam int LINES      = 1 << INDEX_BITS;
	localparam int TAG_BITS   = ADDR_BITS - INDEX_BITS;
	localparam int ENTRY_BITS = 1 + TAG_BITS + COUNT_BITS;
	localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;

	logic [1:0]            state_q;
	logic [INDEX_BITS-1:0] clr_q;
	fetch_t                item_q;
	result_t               result_q;
	logic                  result_valid_q;

	logic [THR_BITS-1:0]   threshold_q;
	logic [TOTAL_BITS-1:0] warmup_len_q;
	logic [TOTAL_BITS-1:0] warmup_rem_q;
	logic [TOTAL_BITS-1:0] accesses_q;
	logic [TOTAL_BITS-1:0] misses_q;

	// line RAM word: {valid, tag, miss count}
	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	logic [ENTRY_BITS-1:0] ram_wdata;
	logic [ENTRY_BITS-1:0] ram_rdata;
	logic                  accept;

	logic                  cfg_wr;
	logic [REG_IDX_BITS-1:0] reg_idx;

	logic                  is_ifetch;
	logic                  warm;
	logic [INDEX_BITS-1:0] line;
	logic [TAG_BITS-1:0]   tag;
	logic                  ent_valid;
	logic [TAG_BITS-1:0]   ent_tag;
	logic [COUNT_BITS-1:0] ent_cnt;
	logic                  tag_hit;
	logic                  load;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [ENTRY_BITS-1:0] new_entry;
	logic [TOTAL_BITS-1:0] acc_next;
	logic [TOTAL_BITS-1:0] miss_next;
	logic                  update;

	assign accept      = fetch_valid && fetch_ready;
	assign fetch_ready = (state_q == ST_IDLE);

	dmx_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (LINES)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (fetch.fetch_address[INDEX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// lookup and line update, on the RAM read data
	always_comb begin
		is_ifetch = !item_q.data_fetch;
		warm      = (warmup_rem_q != '0);
		line      = item_q.fetch_address[INDEX_BITS-1:0];
		tag       = item_q.fetch_address[ADDR_BITS-1:INDEX_BITS];
		ent_valid = ram_rdata[ENTRY_BITS-1];
		ent_tag   = ram_rdata[ENTRY_BITS-2 -: TAG_BITS];
		ent_cnt   = ram_rdata[COUNT_BITS-1:0];
		tag_hit   = ent_valid && (ent_tag == tag);
		// warm-up forces threshold to zero, so every miss loads
		load      = !tag_hit &&
			(warm || (CMP_BITS'(ent_cnt) >= CMP_BITS'(threshold_q)));
		if (tag_hit || load) begin
			new_cnt = '0;
		end else if (ent_cnt == '1) begin
			new_cnt = ent_cnt;
		end else begin
			new_cnt = ent_cnt + 1'b1;
		end
		new_entry = {ent_valid || load, load ? tag : ent_tag, new_cnt};

		acc_next  = accesses_q;
		miss_next = misses_q;
		if (is_ifetch && !warm) begin
			if (accesses_q != '1) begin
				acc_next = accesses_q + 1'b1;
			end
			if (!tag_hit && (misses_q != '1)) begin
				miss_next = misses_q + 1'b1;
			end
		end

		update = (state_q == ST_LOOK) && (!result_valid_q || result_ready);

		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = {1'b0, {TAG_BITS{1'b0}}, {COUNT_BITS{1'b1}}};
		end else begin
			ram_we    = update && is_ifetch;
			ram_waddr = line;
			ram_wdata = new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
			accesses_q     <= '0;
			misses_q       <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (update) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (update) begin
				result_valid_q <= 1'b1;
				accesses_q     <= acc_next;
				misses_q       <= miss_next;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= fetch;
		end
		if (update) begin
			result_q.counted      <= is_ifetch;
			result_q.hit          <= is_ifetch && tag_hit;
			result_q.replaced     <= is_ifetch && load;
			result_q.in_warmup    <= warm;
			result_q.access_total <= acc_next;
			result_q.miss_total   <= miss_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// configuration registers; a warm-up write restarts the warm-up count
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[APB_ADDR_BITS-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= '0;
			warmup_len_q <= '0;
			warmup_rem_q <= '0;
		end else begin
			if (update && is_ifetch && warm) begin
				warmup_rem_q <= warmup_rem_q - 1'b1;
			end
			if (cfg_wr) begin
				case (reg_idx)
					REG_THRESHOLD: begin
						threshold_q <= pwdata[THR_BITS-1:0];
					end
					REG_WARMUP: begin
						warmup_len_q <= pwdata[TOTAL_BITS-1:0];
						warmup_rem_q <= pwdata[TOTAL_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = APB_DATA_BITS'(threshold_q);
			REG_WARMUP:    prdata = APB_DATA_BITS'(warmup_len_q);
			default:       prdata = '0;
		endcase
	end

endmodule

@@ design/dmx_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module dmx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the dynamic-exclusion direct-mapped cache core.
module testbench;
	import dmx_pkg::*;

	localparam int INDEX_BITS    = INDEX_BITS_DEF;
	localparam int COUNT_BITS    = COUNT_BITS_DEF;
	localparam int TAG_BITS      = ADDR_BITS - INDEX_BITS;
	localparam int LINES         = 1 << INDEX_BITS;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 225;

	logic                     clk;
	logic                     arst_n;
	logic                     fetch_valid;
	logic                     fetch_ready;
	fetch_t                   fetch;
	logic                     result_valid;
	logic                     result_ready;
	result_t                  result;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	// predicted cache contents and counters
	logic [TAG_BITS-1:0]   line_tag [LINES];
	bit                    line_loaded [LINES];
	logic [COUNT_BITS-1:0] line_misses [LINES];
	logic [THR_BITS-1:0]   miss_limit;
	logic [TOTAL_BITS-1:0] warmup_len;
	logic [TOTAL_BITS-1:0] warmup_left;
	logic [TOTAL_BITS-1:0] access_count;
	logic [TOTAL_BITS-1:0] miss_count;

	fetch_t  fetch_queue[$];
	result_t predicted_results[$];
	int      error_count;
	int      idle_cycles;
	int      send_idle_pct;
	int      recv_stall_pct;
	bit      beat_taken;

	dm_cache_dynamic_exclusion_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.fetch_valid  (fetch_valid),
		.fetch_ready  (fetch_ready),
		.fetch        (fetch),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic fetch_t make_fetch(input logic is_data, input logic [ADDR_BITS-1:0] addr);
		fetch_t f;
		f.data_fetch    = is_data;
		f.fetch_address = addr;
		return f;
	endfunction

	function automatic string fmt_result(input result_t r);
		return $sformatf({"counted=%0d hit=%0d replaced=%0d in_warmup=%0d ",
			"access_total=%0d miss_total=%0d"},
			r.counted, r.hit, r.replaced, r.in_warmup, r.access_total, r.miss_total);
	endfunction

	// Lookup and update of the predicted cache for one fetch beat.
	function automatic result_t cache_lookup(input fetch_t f);
		logic [INDEX_BITS-1:0] idx;
		logic [TAG_BITS-1:0]   tag;
		logic                  warm;
		result_t               r;
		idx  = f.fetch_address[INDEX_BITS-1:0];
		tag  = f.fetch_address[ADDR_BITS-1:INDEX_BITS];
		warm = (warmup_left != '0);
		r    = '0;
		if (!f.data_fetch) begin
			r.counted = 1'b1;
			r.hit     = line_loaded[idx] && (line_tag[idx] == tag);
			if (r.hit) begin
				line_misses[idx] = '0;
			end else if (warm || line_misses[idx] >= miss_limit) begin
				// warm-up acts as a zero threshold
				line_tag[idx]    = tag;
				line_loaded[idx] = 1'b1;
				line_misses[idx] = '0;
				r.replaced       = 1'b1;
			end else if (line_misses[idx] != '1) begin
				line_misses[idx] = line_misses[idx] + 1'b1;
			end
			if (warm) begin
				warmup_left = warmup_left - 1'b1;
			end else begin
				if (access_count != '1)
					access_count = access_count + 1'b1;
				if (!r.hit && miss_count != '1)
					miss_count = miss_count + 1'b1;
			end
		end
		r.in_warmup    = warm;
		r.access_total = access_count;
		r.miss_total   = miss_count;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		error_count = error_count + 1;
		if (error_count <= 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Register write followed by a read back of the same register.
	task automatic write_config(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
		logic [APB_DATA_BITS-1:0] readback;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_THRESHOLD) begin
			miss_limit = value[THR_BITS-1:0];
		end else begin
			warmup_len  = value;
			warmup_left = value;
		end
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		readback = (idx == REG_THRESHOLD) ? APB_DATA_BITS'(miss_limit) : warmup_len;
		if (prdata !== readback)
			note_failure($sformatf("register %0d read back: expected %0h, got %0h",
				idx, readback, prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		while (fetch_queue.size() != 0 || predicted_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// fetch driver and result-side stall, both at the falling edge
	always @(negedge clk) begin
		logic offer;
		offer = (fetch_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
		if (!fetch_valid || beat_taken) begin
			fetch_valid <= offer;
			if (offer)
				fetch <= fetch_queue[0];
		end
		beat_taken = 1'b0;
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor, predictor hook and watchdog
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (predicted_results.size() == 0) begin
					note_failure($sformatf("result with nothing expected: %s", fmt_result(result)));
				end else begin
					want = predicted_results.pop_front();
					if (result.counted !== want.counted || result.hit !== want.hit ||
					    result.replaced !== want.replaced || result.in_warmup !== want.in_warmup ||
					    result.access_total !== want.access_total ||
					    result.miss_total !== want.miss_total)
						note_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
							fmt_result(want), fmt_result(result)));
				end
			end
			if (fetch_valid && fetch_ready) begin
				predicted_results.push_back(cache_lookup(fetch));
				void'(fetch_queue.pop_front());
				beat_taken = 1'b1;
			end
			if ((fetch_valid && fetch_ready) || (result_valid && result_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles = idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [INDEX_BITS-1:0] line_pool [16];
		logic [TAG_BITS-1:0]   tag_pool [4];
		int                    n_lines;
		int                    n_tags;
		int                    phase;
		int                    n;
		int                    pick;
		logic [31:0]           thr_val;
		logic [31:0]           warm_val;
		logic [31:0]           rnd;

		arst_n         = 1'b0;
		fetch_valid    = 1'b0;
		fetch          = '0;
		result_ready   = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		error_count    = 0;
		idle_cycles    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		beat_taken     = 1'b0;
		for (n = 0; n < LINES; n++) begin
			line_tag[n]    = '0;
			line_loaded[n] = 1'b0;
			line_misses[n] = '1;
		end
		miss_limit   = '0;
		warmup_len   = '0;
		warmup_left  = '0;
		access_count = '0;
		miss_count   = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: warm-up boundary, exclusion count, hit clearing, data fetches
		write_config(REG_THRESHOLD, 32'd2);
		write_config(REG_WARMUP, 32'd3);
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_0000));
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_0000));
		fetch_queue.push_back(make_fetch(1'b1, 30'h3fff_ffff));
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ffff));  // last warm-up beat
		fetch_queue.push_back(make_fetch(1'b1, 30'h0000_0000));
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ff00));
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ff00));
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ff00));  // count at limit, line replaced
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ff00));
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_0000));
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ff00));  // hit clears count
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_0000));
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_0000));
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_0000));
		fetch_queue.push_back(make_fetch(1'b0, 30'h2aaa_aaaa));
		fetch_queue.push_back(make_fetch(1'b0, 30'h1555_5555));
		fetch_queue.push_back(make_fetch(1'b0, 30'h1555_55aa));
		fetch_queue.push_back(make_fetch(1'b0, 30'h2aaa_aaaa));
		fetch_queue.push_back(make_fetch(1'b1, 30'h1555_5555));
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_00ff));
		drain();
		write_config(REG_THRESHOLD, 32'd0);
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_00ff));
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ffff));
		drain();
		write_config(REG_THRESHOLD, 32'h0000_ffff);
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_00ff));
		fetch_queue.push_back(make_fetch(1'b0, 30'h0000_00ff));
		fetch_queue.push_back(make_fetch(1'b0, 30'h3fff_ffff));
		drain();

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin thr_val = 32'd0;                        warm_val = 32'd0;         end
				1: begin thr_val = 32'h0000_ffff;                warm_val = 32'd10;        end
				2: begin thr_val = 32'd1;                        warm_val = 32'hffff_ffff; end
				3: begin thr_val = 32'd3;                        warm_val = 32'd0;         end
				4: begin thr_val = $urandom_range(6);            warm_val = $urandom_range(50); end
				5: begin thr_val = 32'd2;                        warm_val = 32'd1;         end
				6: begin thr_val = $urandom & 32'h0000_ffff;     warm_val = 32'd0;         end
				default: begin thr_val = $urandom_range(4);      warm_val = 32'd25;        end
			endcase
			write_config(REG_THRESHOLD, thr_val);
			write_config(REG_WARMUP, warm_val);
			send_idle_pct  = (phase % 4 == 1) ? 69 : (phase % 4 == 3) ? 34 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 69 : (phase % 4 == 3) ? 34 : 0;

			// a few conflicting tags on a few lines drive the exclusion logic
			n_lines = $urandom_range(12, 2);
			n_tags  = $urandom_range(4, 2);
			for (n = 0; n < n_lines; n++)
				line_pool[n] = INDEX_BITS'($urandom);
			for (n = 0; n < n_tags; n++)
				tag_pool[n] = TAG_BITS'($urandom);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				rnd  = $urandom;
				if (pick < 12)
					fetch_queue.push_back(make_fetch(1'b1, rnd[ADDR_BITS-1:0]));
				else if (pick < 22)
					fetch_queue.push_back(make_fetch(1'b0, rnd[ADDR_BITS-1:0]));
				else
					fetch_queue.push_back(make_fetch(1'b0, {tag_pool[$urandom_range(n_tags - 1)],
						line_pool[$urandom_range(n_lines - 1)]}));
			end
			drain();
		end

		if (error_count == 0 && predicted_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
